// ===== src/brms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_pkg
// Shared types and constants for the bend/return motion sequencer.
// ----------------------------------------------------------------------------
package brms_pkg;

    localparam int HOLD_W      = 24;   // hold counter width
    localparam int ANGLE_W     = 16;
    localparam int ACTION_W    = 2;
    localparam int REPEAT_W    = 16;
    localparam int CFG_HOLD_W  = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEND_SENSE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEND_HOLD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_HOLD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_LIMIT = 3'd5;

    localparam logic [ANGLE_W-1:0]    RST_ANGLE = 16'd2500;
    localparam logic [CFG_HOLD_W-1:0] RST_HOLD  = 24'd1000;

    localparam logic MOTOR_FIRST  = 1'b0;
    localparam logic MOTOR_SECOND = 1'b1;
    localparam logic DIR_RETURN   = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_DOWN        = 3'd1,
        PH_UP          = 3'd2,
        PH_DOWN_HOLD   = 3'd3,
        PH_UP_HOLD     = 3'd4,
        PH_RETURN      = 3'd5,
        PH_RETURN_HOLD = 3'd6
    } phase_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]    angle_first;
        logic [ANGLE_W-1:0]    angle_second;
        logic                  bend_sense;
        logic [CFG_HOLD_W-1:0] bend_hold;
        logic [CFG_HOLD_W-1:0] return_hold;
        logic [REPEAT_W-1:0]   repeat_limit;
    } cfg_t;

    typedef struct packed {
        logic               motor_index;
        logic               move_direction;
        logic [ANGLE_W-1:0] target_angle;
        logic               last;
        logic               running;
    } res_t;

    // Results caused by one request: count 0..2, first two entries used.
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } push_t;

endpackage

`default_nettype wire

// ===== src/brms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_in_if / brms_out_if
// Valid/ready channels for requests and motor commands.
// ----------------------------------------------------------------------------
interface brms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       motion_done;

    modport source (output valid, output action, output motion_done, input ready);
    modport sink   (input valid, input action, input motion_done, output ready);
endinterface

interface brms_out_if;
    logic        valid;
    logic        ready;
    logic        motor_index;
    logic        move_direction;
    logic [15:0] target_angle;
    logic        last;
    logic        running;

    modport source (output valid, output motor_index, output move_direction,
                    output target_angle, output last, output running, input ready);
    modport sink   (input valid, input motor_index, input move_direction,
                    input target_angle, input last, input running, output ready);
endinterface

`default_nettype wire

// ===== src/brms_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_cfg_regs
// Configuration register file, write only, indexed writes.
// ----------------------------------------------------------------------------
module brms_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [brms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [brms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output brms_pkg::cfg_t                       cfg
);
    import brms_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_first  <= RST_ANGLE;
            cfg_reg.angle_second <= RST_ANGLE;
            cfg_reg.bend_sense   <= 1'b0;
            cfg_reg.bend_hold    <= RST_HOLD;
            cfg_reg.return_hold  <= RST_HOLD;
            cfg_reg.repeat_limit <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_FIRST:  cfg_reg.angle_first  <= cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_SECOND: cfg_reg.angle_second <= cfg_data[ANGLE_W-1:0];
                CFG_BEND_SENSE:   cfg_reg.bend_sense   <= cfg_data[0];
                CFG_BEND_HOLD:    cfg_reg.bend_hold    <= cfg_data[CFG_HOLD_W-1:0];
                CFG_RETURN_HOLD:  cfg_reg.return_hold  <= cfg_data[CFG_HOLD_W-1:0];
                CFG_REPEAT_LIMIT: cfg_reg.repeat_limit <= cfg_data[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/brms_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_step
// Sequencer state and the per-request update producing up to two commands.
// ----------------------------------------------------------------------------
module brms_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [brms_pkg::ACTION_W-1:0] action,
    input  wire logic                          motion_done,
    input  wire brms_pkg::cfg_t                cfg,
    output brms_pkg::push_t                    push
);
    import brms_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [REPEAT_W-1:0] returns_reg, returns_next;
    logic                down_last_reg, down_last_next;

    logic [HOLD_W-1:0]   bend_hold_ld;
    logic [HOLD_W-1:0]   return_hold_ld;
    logic [REPEAT_W-1:0] returns_inc;
    logic                return_end;
    logic [1:0]          count;
    res_t                res0, res1;

    assign bend_hold_ld   = HOLD_W'(cfg.bend_hold);
    assign return_hold_ld = HOLD_W'(cfg.return_hold);
    assign returns_inc    = (returns_reg == '1) ? returns_reg : returns_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        hold_next      = hold_reg;
        returns_next   = returns_reg;
        down_last_next = down_last_reg;
        return_end     = 1'b0;
        count          = 2'd0;
        res0           = '{MOTOR_FIRST, DIR_RETURN, '0, 1'b0, 1'b0};
        res1           = '{MOTOR_SECOND, DIR_RETURN, '0, 1'b0, 1'b0};

        case (action)
            ACT_START:
            begin
                phase_next     = PH_DOWN;
                hold_next      = '0;
                returns_next   = '0;
                down_last_next = 1'b1;
                count          = 2'd1;
                res0           = '{MOTOR_FIRST, cfg.bend_sense, cfg.angle_first, 1'b0, 1'b0};
            end
            ACT_STOP:
            begin
                phase_next   = PH_IDLE;
                hold_next    = '0;
                returns_next = '0;
                count        = 2'd2;
            end
            ACT_TICK:
            begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_DOWN, PH_UP:
                    begin
                        if (motion_done)
                        begin
                            hold_next = bend_hold_ld;
                            if (bend_hold_ld != '0)
                                phase_next = (phase_reg == PH_DOWN) ? PH_DOWN_HOLD : PH_UP_HOLD;
                            else
                            begin
                                phase_next = PH_RETURN;
                                count      = 2'd2;
                            end
                        end
                    end
                    PH_DOWN_HOLD, PH_UP_HOLD:
                    begin
                        if (hold_reg != '0)
                            hold_next = hold_reg - 1'b1;
                        else
                        begin
                            phase_next = PH_RETURN;
                            count      = 2'd2;
                        end
                    end
                    PH_RETURN:
                    begin
                        if (motion_done)
                        begin
                            hold_next = return_hold_ld;
                            if (return_hold_ld != '0)
                                phase_next = PH_RETURN_HOLD;
                            else
                                return_end = 1'b1;
                        end
                    end
                    PH_RETURN_HOLD:
                    begin
                        if (hold_reg != '0)
                            hold_next = hold_reg - 1'b1;
                        else
                            return_end = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase

                if (return_end)
                begin
                    returns_next = returns_inc;
                    if (cfg.repeat_limit != '0 && returns_inc >= cfg.repeat_limit)
                        phase_next = PH_IDLE;
                    else if (down_last_reg)
                    begin
                        down_last_next = 1'b0;
                        phase_next     = PH_UP;
                        count          = 2'd1;
                        res0 = '{MOTOR_SECOND, cfg.bend_sense, cfg.angle_second, 1'b0, 1'b0};
                    end
                    else
                    begin
                        down_last_next = 1'b1;
                        phase_next     = PH_DOWN;
                        count          = 2'd1;
                        res0 = '{MOTOR_FIRST, cfg.bend_sense, cfg.angle_first, 1'b0, 1'b0};
                    end
                end
            end
            default: ;
        endcase

        // last marks the final command of this request
        res0.last    = (count == 2'd1);
        res1.last    = 1'b1;
        res0.running = (phase_next != PH_IDLE);
        res1.running = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hold_reg      <= '0;
            returns_reg   <= '0;
            down_last_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            returns_reg   <= returns_next;
            down_last_reg <= down_last_next;
        end
    end

    assign push.count = accept ? count : 2'd0;
    assign push.res0  = res0;
    assign push.res1  = res1;

endmodule

`default_nettype wire

// ===== src/brms_res_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brms_res_queue
// Small result queue taking up to two commands a cycle, releasing one while out_ready is high.
// ----------------------------------------------------------------------------
module brms_res_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire brms_pkg::push_t push,
    output logic                 space,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output brms_pkg::res_t       out_res
);
    import brms_pkg::*;

    res_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;
    logic                   pop;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + QUEUE_PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign count_next   = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

    // room for the worst case of two commands
    assign space     = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.res1;
    end

endmodule

`default_nettype wire

// ===== src/bend_return_motion_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bend_return_motion_sequencer
// Sequences two joint motors through bend, hold, return and hold phases.
// ----------------------------------------------------------------------------
// Commands of an accepted request are registered into the result queue and leave
// after older queued ones. Requests are taken one per cycle while the queue has
// room for two; the four-entry result queue sets how far requests run ahead.
// Reset: asynchronous, clears sequencer state, queue and registers at once.
module bend_return_motion_sequencer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [brms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [brms_pkg::CFG_DATA_W-1:0]  cfg_data,
    brms_in_if.sink                               request,
    brms_out_if.source                            result
);
    import brms_pkg::*;

    cfg_t  cfg;
    push_t push;
    res_t  out_res;
    logic  space;
    logic  accept;

    assign request.ready = space;
    assign accept        = request.valid && space;

    brms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brms_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (request.action),
        .motion_done (request.motion_done),
        .cfg         (cfg),
        .push        (push)
    );

    brms_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.motor_index    = out_res.motor_index;
    assign result.move_direction = out_res.move_direction;
    assign result.target_angle   = out_res.target_angle;
    assign result.last           = out_res.last;
    assign result.running        = out_res.running;

endmodule

`default_nettype wire

// ===== tb/bend_return_motion_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bend_return_motion_sequencer_tb
// Self-checking bench for the bend/return motion sequencer. A table of
// directed requests and register writes runs first, then random request
// streams under several register settings. Every accepted request goes
// through a cycle-free model of the sequencer, and each motor command that
// leaves the block is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module bend_return_motion_sequencer_tb;
    import brms_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SEGMENTS = 8;
    localparam int SEG_REQUESTS = 45;
    localparam int HOLD_OFF_CYCLES = 60;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [ACTION_W-1:0]    act;
        logic                   done;
        int                     n_typed;   // -1: take the model's answer
        res_t                   t0;
        res_t                   t1;
    } step_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    brms_in_if  req_if ();
    brms_out_if cmd_if ();

    bend_return_motion_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_if),
        .result    (cmd_if)
    );

    // sequencer model state
    cfg_t                reg_copy;
    phase_t              ph;
    logic [HOLD_W-1:0]   hold_left;
    logic [REPEAT_W-1:0] ret_count;
    logic                down_last;

    res_t      exp_cmds [$];
    step_row_t rows [$];

    int fails;
    int requests_sent;
    int cmds_checked;
    int reg_writes;
    int idle_mode;
    int hold_off_req;
    int hold_off_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            0:       return 30;
            1:       return 82;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_mode)
            0:       return 82;
            1:       return 30;
            default: return 0;
        endcase
    endfunction

    function automatic res_t make_cmd(logic m, logic d, logic [ANGLE_W-1:0] a,
                                      logic l, logic r);
        res_t c;
        c.motor_index    = m;
        c.move_direction = d;
        c.target_angle   = a;
        c.last           = l;
        c.running        = r;
        return c;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Advance the model by one request and return the commands it causes.
    task automatic predict_item(input logic [ACTION_W-1:0] act, input logic done,
                                output int n, output res_t c0, output res_t c1);
        logic ret_pair;
        logic ret_end;
        logic bend_on;
        logic bend_motor;
        logic live;
        ret_pair   = 1'b0;
        ret_end    = 1'b0;
        bend_on    = 1'b0;
        bend_motor = MOTOR_FIRST;
        n  = 0;
        c0 = '0;
        c1 = '0;
        case (act)
            ACT_START:
            begin
                ph        = PH_DOWN;
                hold_left = '0;
                ret_count = '0;
                down_last = 1'b1;
                bend_on   = 1'b1;
            end
            ACT_STOP:
            begin
                ph        = PH_IDLE;
                hold_left = '0;
                ret_count = '0;
                ret_pair  = 1'b1;
            end
            ACT_TICK:
            begin
                case (ph)
                    PH_IDLE: ;
                    PH_DOWN, PH_UP:
                    begin
                        if (done)
                        begin
                            hold_left = reg_copy.bend_hold;
                            if (hold_left != 0)
                                ph = (ph == PH_DOWN) ? PH_DOWN_HOLD : PH_UP_HOLD;
                            else
                            begin
                                ph       = PH_RETURN;
                                ret_pair = 1'b1;
                            end
                        end
                    end
                    PH_DOWN_HOLD, PH_UP_HOLD:
                    begin
                        if (hold_left != 0)
                            hold_left--;
                        else
                        begin
                            ph       = PH_RETURN;
                            ret_pair = 1'b1;
                        end
                    end
                    PH_RETURN:
                    begin
                        if (done)
                        begin
                            hold_left = reg_copy.return_hold;
                            if (hold_left != 0)
                                ph = PH_RETURN_HOLD;
                            else
                                ret_end = 1'b1;
                        end
                    end
                    PH_RETURN_HOLD:
                    begin
                        if (hold_left != 0)
                            hold_left--;
                        else
                            ret_end = 1'b1;
                    end
                    default: ph = PH_IDLE;
                endcase
            end
            default: ;
        endcase

        // end of a return and its hold: count it, then stop or bend the other motor
        if (ret_end)
        begin
            if (ret_count != '1)
                ret_count++;
            if (reg_copy.repeat_limit != 0 && ret_count >= reg_copy.repeat_limit)
                ph = PH_IDLE;
            else if (down_last)
            begin
                down_last  = 1'b0;
                ph         = PH_UP;
                bend_on    = 1'b1;
                bend_motor = MOTOR_SECOND;
            end
            else
            begin
                down_last = 1'b1;
                ph        = PH_DOWN;
                bend_on   = 1'b1;
            end
        end

        live = (ph != PH_IDLE);
        if (bend_on)
        begin
            c0 = make_cmd(bend_motor, reg_copy.bend_sense,
                          (bend_motor == MOTOR_SECOND) ? reg_copy.angle_second
                                                       : reg_copy.angle_first,
                          1'b1, live);
            n = 1;
        end
        if (ret_pair)
        begin
            c0 = make_cmd(MOTOR_FIRST, DIR_RETURN, '0, 1'b0, live);
            c1 = make_cmd(MOTOR_SECOND, DIR_RETURN, '0, 1'b1, live);
            n = 2;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic done,
                             input int n_typed, input res_t t0, input res_t t1);
        int   n;
        res_t p0;
        res_t p1;
        while ($urandom_range(99) < sender_idle_pct())
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= act;
        req_if.motion_done <= done;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_item(act, done, n, p0, p1);
        if (n_typed >= 0)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            exp_cmds.push_back(p0);
        if (n > 1)
            exp_cmds.push_back(p1);
        requests_sent++;
        @(negedge clk);
    endtask

    // Stop offering requests and wait until the block has nothing left to say.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (exp_cmds.size() != 0)
            @(negedge clk);
        // a request without commands may still be in flight
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ANGLE_FIRST:  reg_copy.angle_first  = val[ANGLE_W-1:0];
            CFG_ANGLE_SECOND: reg_copy.angle_second = val[ANGLE_W-1:0];
            CFG_BEND_SENSE:   reg_copy.bend_sense   = val[0];
            CFG_BEND_HOLD:    reg_copy.bend_hold    = val[CFG_HOLD_W-1:0];
            CFG_RETURN_HOLD:  reg_copy.return_hold  = val[CFG_HOLD_W-1:0];
            CFG_REPEAT_LIMIT: reg_copy.repeat_limit = val[REPEAT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_angle();
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_DATA_W'(36000);
            default: return CFG_DATA_W'($urandom_range(36000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_hold();
        return ($urandom_range(3) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 5));
    endfunction

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        step_row_t r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        r.act      = ACT_TICK;
        r.done     = 1'b0;
        r.n_typed  = -1;
        r.t0       = '0;
        r.t1       = '0;
        rows.push_back(r);
    endtask

    task automatic add_req(input logic [ACTION_W-1:0] act, input logic done,
                           input int n_typed, input res_t t0, input res_t t1);
        step_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.act      = act;
        r.done     = done;
        r.n_typed  = n_typed;
        r.t0       = t0;
        r.t1       = t1;
        rows.push_back(r);
    endtask

    task automatic build_rows();
        res_t ret0_idle;
        res_t ret1_idle;
        ret0_idle = make_cmd(MOTOR_FIRST, DIR_RETURN, '0, 1'b0, 1'b0);
        ret1_idle = make_cmd(MOTOR_SECOND, DIR_RETURN, '0, 1'b1, 1'b0);

        // reset settings: idle tick, unused code, start, wait, stop, stop while idle
        add_req(ACT_TICK, 1'b1, 0, '0, '0);
        add_req(ACT_UNUSED, 1'b1, 0, '0, '0);
        add_req(ACT_START, 1'b0, 1, make_cmd(MOTOR_FIRST, 1'b0, RST_ANGLE, 1'b1, 1'b1), '0);
        add_req(ACT_TICK, 1'b0, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_STOP, 1'b0, 2, ret0_idle, ret1_idle);
        add_req(ACT_STOP, 1'b1, 2, ret0_idle, ret1_idle);

        // extreme angles, zero bend hold, two repeats: full cycle down, up, stop
        add_write(CFG_ANGLE_FIRST, 36000);
        add_write(CFG_ANGLE_SECOND, 0);
        add_write(CFG_BEND_SENSE, 1);
        add_write(CFG_BEND_HOLD, 0);
        add_write(CFG_RETURN_HOLD, 1);
        add_write(CFG_REPEAT_LIMIT, 2);
        add_req(ACT_START, 1'b0, 1, make_cmd(MOTOR_FIRST, 1'b1, 16'd36000, 1'b1, 1'b1), '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b0, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b0, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b0, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);

        // full-scale holds are loaded, then cut short by a stop
        add_write(CFG_BEND_HOLD, 24'hFFFFFF);
        add_write(CFG_REPEAT_LIMIT, 16'hFFFF);
        add_req(ACT_START, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_STOP, 1'b0, 2, ret0_idle, ret1_idle);
        add_write(CFG_BEND_HOLD, 0);
        add_write(CFG_RETURN_HOLD, 24'hFFFFFF);
        add_req(ACT_START, 1'b0, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_TICK, 1'b1, -1, '0, '0);
        add_req(ACT_STOP, 1'b1, 2, ret0_idle, ret1_idle);

        add_write(CFG_ANGLE_FIRST, 0);
        add_write(CFG_ANGLE_SECOND, 36000);
        add_write(CFG_BEND_SENSE, 0);
        add_req(ACT_START, 1'b0, 1, make_cmd(MOTOR_FIRST, 1'b0, '0, 1'b1, 1'b1), '0);
        add_req(ACT_STOP, 1'b0, 2, ret0_idle, ret1_idle);
    endtask

    // command checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            if (exp_cmds.size() == 0)
            begin
                $error("unexpected command: motor %0d dir %0d angle %0d",
                       cmd_if.motor_index, cmd_if.move_direction, cmd_if.target_angle);
                fails++;
            end
            else
            begin
                want = exp_cmds.pop_front();
                check_field("motor_index", want.motor_index, cmd_if.motor_index);
                check_field("move_direction", want.move_direction, cmd_if.move_direction);
                check_field("target_angle", want.target_angle, cmd_if.target_angle);
                check_field("last", want.last, cmd_if.last);
                check_field("running", want.running, cmd_if.running);
                cmds_checked++;
            end
        end
    end

    // command receiver: random back-pressure plus a long hold-off when requested
    initial
    begin
        cmd_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                cmd_if.ready <= 1'b0;
                hold_off_left--;
            end
            else if (hold_off_req != 0)
            begin
                hold_off_req  = 0;
                hold_off_left = HOLD_OFF_CYCLES;
                cmd_if.ready <= 1'b0;
            end
            else
                cmd_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    initial
    begin
        logic [ACTION_W-1:0] act;
        logic                done;
        int                  counted;
        int                  r;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.action      = ACT_TICK;
        req_if.motion_done = 1'b0;
        fails          = 0;
        requests_sent  = 0;
        cmds_checked   = 0;
        reg_writes     = 0;
        idle_mode      = 0;
        hold_off_req   = 0;
        hold_off_left  = 0;

        reg_copy.angle_first  = RST_ANGLE;
        reg_copy.angle_second = RST_ANGLE;
        reg_copy.bend_sense   = 1'b0;
        reg_copy.bend_hold    = RST_HOLD;
        reg_copy.return_hold  = RST_HOLD;
        reg_copy.repeat_limit = '0;
        ph        = PH_IDLE;
        hold_left = '0;
        ret_count = '0;
        down_last = 1'b1;

        build_rows();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_write)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                send_item(rows[i].act, rows[i].done, rows[i].n_typed, rows[i].t0, rows[i].t1);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_mode = seg / 3;
            write_reg(CFG_ANGLE_FIRST, pick_angle());
            write_reg(CFG_ANGLE_SECOND, pick_angle());
            write_reg(CFG_BEND_SENSE, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_BEND_HOLD, pick_hold());
            write_reg(CFG_RETURN_HOLD, pick_hold());
            write_reg(CFG_REPEAT_LIMIT,
                      ($urandom_range(1) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 4)));
            // receiver goes quiet while requests keep coming, so the queue backs up
            if (seg == 6)
                hold_off_req = 1;
            counted = 0;
            while (counted < SEG_REQUESTS)
            begin
                r    = $urandom_range(99);
                done = ($urandom_range(99) < 65);
                if (ph == PH_IDLE)
                    act = (r < 85) ? ACT_START : (r < 90) ? ACT_STOP :
                          (r < 95) ? ACT_TICK : ACT_UNUSED;
                else
                    act = (r < 88) ? ACT_TICK : (r < 93) ? ACT_STOP :
                          (r < 96) ? ACT_START : ACT_UNUSED;
                send_item(act, done, -1, '0, '0);
                if (act != ACT_UNUSED)
                    counted++;
            end
        end

        req_if.valid <= 1'b0;
        while (exp_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d requests, %0d motor commands checked, %0d register writes",
                 requests_sent, cmds_checked, reg_writes);
        $display("directed table, %0d random settings, back-pressure both ways and none",
                 SEGMENTS);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
